[design/tbp_pkg.sv]
package tbp_pkg;

	localparam int unsigned LIMIT_W = 4;
	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned LINES_W = 2;
	localparam int unsigned EVENT_W = 3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;
	localparam logic [HOLD_W-1:0]  LONG_RESET  = 16'd199;
	localparam logic [HOLD_W-1:0]  HOLD_MAX    = 16'hFFFF;

	typedef enum logic [0:0] {
		CFG_DEBOUNCE_LIMIT = 1'b0,
		CFG_LONG_PRESS     = 1'b1
	} cfg_index_t;

	typedef enum logic [LINES_W-1:0] {
		PAT_BOTH  = 2'b00,
		PAT_TIMER = 2'b01,
		PAT_POWER = 2'b10,
		PAT_IDLE  = 2'b11
	} pattern_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE        = 3'd0,
		EV_POWER_SHORT = 3'd1,
		EV_TIMER_SHORT = 3'd2,
		EV_POWER_LONG  = 3'd3,
		EV_TIMER_LONG  = 3'd4
	} event_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] debounce_count;
		logic [HOLD_W-1:0]  hold_count;
		logic               long_reported;
		logic [LINES_W-1:0] latched_lines;
	} press_state_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] debounce_limit;
		logic [HOLD_W-1:0]  long_press_ticks;
	} press_cfg_t;

endpackage

[design/two_button_short_long_press_core.sv]
// channel | signals                                   | direction
// in      | in_valid, in_ready, button_lines           | word in
// out     | out_valid, out_ready, event_res           | word out
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// one word per cycle while in_ready is high; the press state updates on the
// cycle a word is accepted; its event appears in the output register on the
// next cycle, or waits in the skid entry while the output register is held
// a two-entry output stage (register plus skid) keeps in_ready high while one
// result waits; in_ready drops only when both entries are full
// reset clears all press state and loads debounce_limit 5, long_press_ticks 199
// cfg_ready is always high
module two_button_short_long_press_core import tbp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LINES_W-1:0] button_lines,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [EVENT_W-1:0] event_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [HOLD_W-1:0]  cfg_data
);

	press_state_t state_q;
	press_state_t state_nxt;
	press_cfg_t   cfg_q;
	event_t       ev;
	logic         accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_limit   <= LIMIT_RESET;
			cfg_q.long_press_ticks <= LONG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEBOUNCE_LIMIT: cfg_q.debounce_limit   <= cfg_data[LIMIT_W-1:0];
				CFG_LONG_PRESS:     cfg_q.long_press_ticks <= cfg_data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	tbp_step u_step (
		.cur   (state_q),
		.cfg   (cfg_q),
		.lines (button_lines),
		.nxt   (state_nxt),
		.ev    (ev)
	);

	tbp_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_ev   (ev),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_res (event_res)
	);

endmodule

[design/tbp_step.sv]
module tbp_step import tbp_pkg::*; (
	input  press_state_t       cur,
	input  press_cfg_t         cfg,
	input  logic [LINES_W-1:0] lines,
	output press_state_t       nxt,
	output event_t             ev
);

	logic [LIMIT_W-1:0] dc_up;
	logic [LIMIT_W-1:0] dc_dn;
	logic [HOLD_W-1:0]  hold_up;

	assign dc_up   = (cur.debounce_count < cfg.debounce_limit) ?
		cur.debounce_count + LIMIT_W'(1) : cur.debounce_count;
	assign dc_dn   = cur.debounce_count - LIMIT_W'(1);
	assign hold_up = cur.hold_count + HOLD_W'(1);

	always_comb begin
		nxt = cur;
		ev  = EV_NONE;
		if (lines != PAT_IDLE) begin
			nxt.debounce_count = dc_up;
			if (dc_up >= cfg.debounce_limit) begin
				nxt.latched_lines = lines;
				if (cur.hold_count <= cfg.long_press_ticks && cur.hold_count != HOLD_MAX) begin
					nxt.hold_count = hold_up;
					if (hold_up == cfg.long_press_ticks) begin
						nxt.long_reported = 1'b1;
						if (lines == PAT_POWER) begin
							ev = EV_POWER_LONG;
						end else if (lines == PAT_TIMER) begin
							ev = EV_TIMER_LONG;
						end
					end
				end
			end
		end else if (cur.debounce_count != '0) begin
			nxt.debounce_count = dc_dn;
			nxt.hold_count     = '0;
			if (dc_dn == '0) begin
				if (cur.long_reported) begin
					nxt.long_reported = 1'b0;
				end else if (cur.latched_lines == PAT_POWER) begin
					ev = EV_POWER_SHORT;
				end else if (cur.latched_lines == PAT_TIMER) begin
					ev = EV_TIMER_SHORT;
				end else begin
					nxt.latched_lines = PAT_BOTH;
				end
			end
		end
	end

endmodule

[design/tbp_out_skid.sv]
module tbp_out_skid import tbp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  event_t             push_ev,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [EVENT_W-1:0] event_res
);

	logic   out_valid_q;
	event_t out_q;
	logic   skid_valid_q;
	event_t skid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign event_res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_ev;
			end else begin
				out_q  <= push_ev;
			end
		end else if (push) begin
			skid_q <= push_ev;
		end
	end

endmodule

[design/tbp_checker.sv]
module tbp_checker import tbp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [EVENT_W-1:0] event_res
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res))
		else $error("result changed while stalled");

	// input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with empty output");

	// a word into an empty output shows next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("result missing one cycle after word");

	// with an empty skid, input stays open unless a word arrives during a stall
	a_one_space: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !(in_valid && out_valid && !out_ready) |=> in_ready)
		else $error("in_ready dropped without a second held word");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= EV_TIMER_LONG)
		else $error("unknown event code");

endmodule

bind two_button_short_long_press_core tbp_checker u_tbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.event_res (event_res)
);

[test/press_event_checker.sv]
module press_event_checker import tbp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [LINES_W-1:0] button_lines,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [EVENT_W-1:0] event_res,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [HOLD_W-1:0]  cfg_data,
	output int                 fail_count,
	output int                 pending_events
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [LIMIT_W-1:0] limit_q;
	logic [HOLD_W-1:0]  long_q;
	logic [LIMIT_W-1:0] db_cnt;
	logic [HOLD_W-1:0]  hold_cnt;
	logic               long_seen;
	pattern_t           latch;
	event_t             expected_events[$];
	event_t             exp_ev;

	function automatic event_t next_event(input logic [LINES_W-1:0] lines);
		event_t ev;
		ev = EV_NONE;
		if (lines != PAT_IDLE) begin
			if (db_cnt < limit_q)
				db_cnt = db_cnt + 1'b1;
			if (db_cnt >= limit_q) begin
				latch = pattern_t'(lines);
				if (hold_cnt <= long_q && hold_cnt != HOLD_MAX) begin
					hold_cnt = hold_cnt + 1'b1;
					if (hold_cnt == long_q) begin
						long_seen = 1'b1;
						if (latch == PAT_POWER)
							ev = EV_POWER_LONG;
						else if (latch == PAT_TIMER)
							ev = EV_TIMER_LONG;
					end
				end
			end
		end else if (db_cnt != '0) begin
			db_cnt = db_cnt - 1'b1;
			hold_cnt = '0;
			if (db_cnt == '0) begin
				if (long_seen)
					long_seen = 1'b0;
				else if (latch == PAT_POWER)
					ev = EV_POWER_SHORT;
				else if (latch == PAT_TIMER)
					ev = EV_TIMER_SHORT;
				else
					latch = PAT_BOTH; // cleared latch
			end
		end
		return ev;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q = LIMIT_RESET;
			long_q = LONG_RESET;
			db_cnt = '0;
			hold_cnt = '0;
			long_seen = 1'b0;
			latch = PAT_BOTH;
			expected_events.delete();
			fail_count = 0;
			pending_events = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_DEBOUNCE_LIMIT: limit_q = cfg_data[LIMIT_W-1:0];
					CFG_LONG_PRESS:     long_q = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$error("event_res: expected no word, got %0d", event_res);
					fail_count++;
				end else begin
					exp_ev = expected_events.pop_front();
					if (event_res !== exp_ev) begin
						$error("event_res: expected %0d, got %0d", exp_ev, event_res);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_events.push_back(next_event(button_lines));
			pending_events = expected_events.size();
		end
	end

endmodule

[test/tb_two_button_short_long_press_core.sv]
module tb_two_button_short_long_press_core;
	timeunit 1ns;
	timeprecision 1ps;
	import tbp_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [LINES_W-1:0] button_lines;
	logic               out_valid;
	logic               out_ready;
	logic [EVENT_W-1:0] event_res;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [0:0]         cfg_index;
	logic [HOLD_W-1:0]  cfg_data;
	int                 fail_count;
	int                 pending_events;

	bit steady_in;
	bit steady_out;
	bit squeeze_req;
	int sent_words;
	int cur_limit;
	int cur_long;

	two_button_short_long_press_core uut (.*);
	press_event_checker press_chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** two_button_short_long_press_core: FAILED **");
		$finish;
	end

	function automatic int pick_gap(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input logic [LINES_W-1:0] lines);
		int gap;
		gap = pick_gap(steady_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		button_lines <= lines;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_words++;
		@(negedge clk);
	endtask

	task automatic hold_lines(input logic [LINES_W-1:0] lines, input int n);
		repeat (n) send_word(lines);
	endtask

	// only once every expected word is back
	task automatic write_reg(input cfg_index_t idx, input logic [HOLD_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_events != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_DEBOUNCE_LIMIT)
			cur_limit = int'(value[LIMIT_W-1:0]);
		else
			cur_long = int'(value);
	endtask

	task automatic set_config(input logic [LIMIT_W-1:0] limit, input logic [HOLD_W-1:0] ticks);
		logic [HOLD_W-LIMIT_W-1:0] junk;
		junk = (HOLD_W-LIMIT_W)'($urandom());
		write_reg(CFG_DEBOUNCE_LIMIT, {junk, limit});
		write_reg(CFG_LONG_PRESS, ticks);
	endtask

	task automatic run_press();
		int r;
		int n;
		int bound;
		logic [LINES_W-1:0] pat;
		r = $urandom_range(0, 99);
		bound = cur_limit + cur_long + 4;
		if (bound > 70)
			bound = 70;
		if (r < 60) begin
			case ($urandom_range(0, 4))
				0, 1: pat = PAT_POWER;
				2, 3: pat = PAT_TIMER;
				default: pat = PAT_BOTH;
			endcase
			hold_lines(pat, $urandom_range(1, bound));
			hold_lines(PAT_IDLE, $urandom_range(1, cur_limit + 2));
		end else if (r < 80) begin
			n = $urandom_range(1, bound);
			repeat (n) send_word(LINES_W'($urandom_range(0, 2)));
			hold_lines(PAT_IDLE, $urandom_range(1, cur_limit + 2));
		end else begin
			n = $urandom_range(1, 8);
			repeat (n) send_word(LINES_W'($urandom_range(0, 3)));
		end
	endtask

	// receiver side, stalls counted here
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (squeeze_req) begin
					squeeze_req = 1'b0;
					stall_left = 80;
				end else begin
					stall_left = pick_gap(steady_out);
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int phase_start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		button_lines = PAT_IDLE;
		cfg_valid = 1'b0;
		cfg_index = CFG_DEBOUNCE_LIMIT;
		cfg_data = '0;
		steady_in = 1'b0;
		steady_out = 1'b0;
		squeeze_req = 1'b0;
		sent_words = 0;
		cur_limit = LIMIT_RESET;
		cur_long = LONG_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(PAT_IDLE);
		set_config(1, 3);
		send_word(PAT_IDLE);
		hold_lines(PAT_POWER, 1);
		hold_lines(PAT_IDLE, 1);
		hold_lines(PAT_TIMER, 1);
		hold_lines(PAT_IDLE, 1);
		hold_lines(PAT_BOTH, 1);
		hold_lines(PAT_IDLE, 1);
		hold_lines(PAT_POWER, 4);
		hold_lines(PAT_IDLE, 1);
		hold_lines(PAT_TIMER, 4);
		hold_lines(PAT_IDLE, 1);
		hold_lines(PAT_BOTH, 4);
		hold_lines(PAT_IDLE, 1);

		// short report, then a glitch below the limit reports again
		set_config(2, 3);
		hold_lines(PAT_POWER, 2);
		hold_lines(PAT_IDLE, 2);
		send_word(PAT_TIMER);
		send_word(PAT_IDLE);

		// limit lowered under a running count
		set_config(3, 5);
		hold_lines(PAT_POWER, 3);
		set_config(1, 5);
		hold_lines(PAT_POWER, 2);
		hold_lines(PAT_IDLE, 3);

		// zero limit and zero long count
		set_config(0, 0);
		hold_lines(PAT_TIMER, 3);
		hold_lines(PAT_IDLE, 2);

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: set_config(1, 1);
				1: set_config(15, HOLD_W'($urandom_range(2, 30)));
				5: set_config(LIMIT_W'($urandom_range(1, 15)), 16'd65534);
				default: set_config(LIMIT_W'($urandom_range(1, 15)),
					HOLD_W'($urandom_range(1, 40)));
			endcase
			steady_in = (phase == 4);
			steady_out = (phase == 4 || phase == 7);
			phase_start = sent_words;
			if (phase == 2) begin
				// receiver holds off while words keep coming
				squeeze_req = 1'b1;
				steady_in = 1'b1;
				repeat (16) send_word(LINES_W'($urandom_range(0, 3)));
				steady_in = 1'b0;
			end
			while (sent_words - phase_start < 125)
				run_press();
		end

		in_valid <= 1'b0;
		for (int i = 0; i < 20000 && pending_events != 0; i++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending_events == 0)
			$display("** two_button_short_long_press_core: PASSED **");
		else
			$display("** two_button_short_long_press_core: FAILED **");
		$finish;
	end

endmodule

[two_button_short_long_press_core.f]
design/tbp_pkg.sv
design/tbp_step.sv
design/tbp_out_skid.sv
design/two_button_short_long_press_core.sv
design/tbp_checker.sv
test/press_event_checker.sv
test/tb_two_button_short_long_press_core.sv
